>>> sv/csdm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the concentric square-to-disk mapper.
package csdm_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int XY_W         = SAMPLE_BITS + 2;   // signed 2u-1 scaled by 2^B
    localparam int R_W          = SAMPLE_BITS + 1;   // radius and |n|, up to 2^B
    localparam int FRAC         = 30;                // Q0.30 angle, Q1.30 series
    localparam int DIV_STEPS    = FRAC + 1;          // quotient bits 30..0
    localparam int SERIES_STEPS = 3;
    localparam int NUM_STAGES   = 1 + DIV_STEPS + 2 + 3 * SERIES_STEPS + 3 + 1;
    localparam int OUT_W        = 16;

    localparam logic [FRAC:0]   ONE_Q30 = {1'b1, {FRAC{1'b0}}};
    localparam logic [FRAC-1:0] PI4_Q30 = 30'd843314857;

    // Series divisors and floor(2^32 / d) for reciprocal division.
    localparam logic [5:0]  SIN_DIV [SERIES_STEPS] = '{6'd42, 6'd20, 6'd6};
    localparam logic [5:0]  COS_DIV [SERIES_STEPS] = '{6'd56, 6'd30, 6'd12};
    localparam logic [31:0] SIN_RCP [SERIES_STEPS] =
        '{32'd102261126, 32'd214748364, 32'd715827882};
    localparam logic [31:0] COS_RCP [SERIES_STEPS] =
        '{32'd76695844, 32'd143165576, 32'd357913941};

    typedef enum logic [1:0] {
        REG_RIGHT  = 2'd0,
        REG_BOTTOM = 2'd1,
        REG_TOP    = 2'd2,
        REG_LEFT   = 2'd3
    } region_t;

    typedef struct packed {
        region_t        region;
        logic           nneg;
        logic           rzero;
        logic [R_W-1:0] r;
    } ctl_t;

    typedef struct packed {
        ctl_t            ctl;
        logic [FRAC-1:0] a;
        logic [FRAC-1:0] a2;
    } car_t;

endpackage

>>> sv/concentric_square_to_disk_map.sv
`timescale 1ns / 1ps
// Concentric square-to-disk mapper: region select, ratio divide, sin/cos series, scale.
//
// Maps one unit-square sample (u,v) per cycle, when not stalled, onto the unit disk. The pipeline is
// 47 stages deep: a 31-stage restoring divider (one quotient bit per stage), then
// the pi/4 scale, the angle square, three sin/cos series steps of three stages each
// (product, reciprocal multiply, correction) and the final radius scaling. Throughput is one
// word per cycle unless stalled. The whole pipeline advances together and
// freezes while a finished word waits on m_axis_tready.
module concentric_square_to_disk_map
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] sample_u, [31:16] sample_v
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] disk_x, [31:16] disk_y
);

    localparam int B    = csdm_pkg::SAMPLE_BITS;
    localparam int XW   = csdm_pkg::XY_W;
    localparam int RW   = csdm_pkg::R_W;
    localparam int F    = csdm_pkg::FRAC;
    localparam int ND   = csdm_pkg::DIV_STEPS;
    localparam int NS   = csdm_pkg::SERIES_STEPS;
    localparam int NST  = csdm_pkg::NUM_STAGES;
    localparam int OW   = csdm_pkg::OUT_W;

    logic           en;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;

    assign en            = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NST-1];
    assign vld_next      = {vld_reg[NST-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 0: region decode ----------------
    logic signed [XW-1:0] x, y, nx, ny, n_sel, r_sel;
    csdm_pkg::region_t    region;
    csdm_pkg::ctl_t       in_ctl_next, in_ctl_reg;
    logic [RW-1:0]        in_rem_next, in_rem_reg;
    logic signed [XW-1:0] n_abs;

    always_comb
    begin
        x  = $signed({1'b0, s_axis_tdata[B-1:0], 1'b0}) - $signed({2'b01, {B{1'b0}}});
        y  = $signed({1'b0, s_axis_tdata[16+B-1:16], 1'b0}) - $signed({2'b01, {B{1'b0}}});
        nx = -x;
        ny = -y;
        if (x > y)
        begin
            if (x > ny)
            begin
                region = csdm_pkg::REG_RIGHT;
                r_sel  = x;
                n_sel  = y;
            end
            else
            begin
                region = csdm_pkg::REG_BOTTOM;
                r_sel  = ny;
                n_sel  = x;
            end
        end
        else
        begin
            if (x > ny)
            begin
                region = csdm_pkg::REG_TOP;
                r_sel  = y;
                n_sel  = nx;
            end
            else
            begin
                region = csdm_pkg::REG_LEFT;
                r_sel  = nx;
                n_sel  = ny;
            end
        end
        n_abs              = n_sel[XW-1] ? -n_sel : n_sel;
        in_ctl_next.region = region;
        in_ctl_next.nneg   = n_sel[XW-1];
        in_ctl_next.r      = r_sel[RW-1:0];
        in_ctl_next.rzero  = (r_sel == '0);
        in_rem_next        = n_abs[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_ctl_reg <= in_ctl_next;
            in_rem_reg <= in_rem_next;
        end
    end

    // ---------------- divider: T = floor(|n| * 2^30 / r) ----------------
    csdm_pkg::ctl_t dv_ctl_reg [ND];
    logic [RW-1:0]  dv_rem_reg [ND];
    logic [F:0]     dv_q_reg   [ND];

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        csdm_pkg::ctl_t ctl_in;
        logic [RW-1:0]  rem_in;
        logic [F:0]     q_in;
        logic [RW:0]    trial;
        logic [RW:0]    diff;
        logic           qbit;

        if (i == 0)
        begin : g_first
            assign ctl_in = in_ctl_reg;
            assign rem_in = in_rem_reg;
            assign q_in   = '0;
            assign trial  = {1'b0, rem_in};
        end
        else
        begin : g_rest
            assign ctl_in = dv_ctl_reg[i-1];
            assign rem_in = dv_rem_reg[i-1];
            assign q_in   = dv_q_reg[i-1];
            assign trial  = {rem_in, 1'b0};
        end

        assign diff = trial - {1'b0, ctl_in.r};
        assign qbit = !ctl_in.rzero && (trial >= {1'b0, ctl_in.r});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_ctl_reg[i] <= ctl_in;
                dv_rem_reg[i] <= qbit ? diff[RW-1:0] : trial[RW-1:0];
                dv_q_reg[i]   <= {q_in[F-1:0], qbit};
            end
        end
    end

    // ---------------- angle and its square ----------------
    logic [2*F:0]   a_prod;
    logic [2*F-1:0] a2_prod;
    csdm_pkg::ctl_t a_ctl_reg;
    logic [F-1:0]   a_reg;
    csdm_pkg::car_t a2_car_reg;

    assign a_prod  = dv_q_reg[ND-1] * csdm_pkg::PI4_Q30;
    assign a2_prod = a_reg * a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctl_reg         <= dv_ctl_reg[ND-1];
            a_reg             <= a_prod[2*F-1:F];
            a2_car_reg.ctl    <= a_ctl_reg;
            a2_car_reg.a      <= a_reg;
            a2_car_reg.a2     <= a2_prod[2*F-1:F];
        end
    end

    // ---------------- series steps: val = 1 - ((a2*val)>>30) / d ----------------
    csdm_pkg::car_t p_car_reg [NS];
    logic [F-1:0]   p_s_reg   [NS];
    logic [F-1:0]   p_c_reg   [NS];
    csdm_pkg::car_t m_car_reg [NS];
    logic [F-1:0]   m_sp_reg  [NS];
    logic [F-1:0]   m_cp_reg  [NS];
    logic [F+31:0]  m_sm_reg  [NS];
    logic [F+31:0]  m_cm_reg  [NS];
    csdm_pkg::car_t c_car_reg [NS];
    logic [F:0]     c_s_reg   [NS];
    logic [F:0]     c_c_reg   [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_ser
        csdm_pkg::car_t car_in;
        logic [F-1:0]   s_p, c_p;
        logic [F-1:0]   s_q0, c_q0;
        logic [F+5:0]   s_back, c_back;
        logic [F+5:0]   s_rem, c_rem;
        logic [F-1:0]   s_q, c_q;

        if (k == 0)
        begin : g_first
            // first step starts from 1, so the product is a2 itself
            assign car_in = a2_car_reg;
            assign s_p    = car_in.a2;
            assign c_p    = car_in.a2;
        end
        else
        begin : g_rest
            logic [F:0]     s_in, c_in;
            logic [2*F:0]   s_prod, c_prod;

            assign car_in = c_car_reg[k-1];
            assign s_in   = c_s_reg[k-1];
            assign c_in   = c_c_reg[k-1];
            assign s_prod = car_in.a2 * s_in;
            assign c_prod = car_in.a2 * c_in;
            assign s_p    = s_prod[2*F-1:F];
            assign c_p    = c_prod[2*F-1:F];
        end

        always_comb
        begin
            s_q0   = m_sm_reg[k][F+31:32];
            c_q0   = m_cm_reg[k][F+31:32];
            s_back = s_q0 * csdm_pkg::SIN_DIV[k];
            c_back = c_q0 * csdm_pkg::COS_DIV[k];
            s_rem  = {6'd0, m_sp_reg[k]} - s_back;
            c_rem  = {6'd0, m_cp_reg[k]} - c_back;
            // reciprocal estimate is at most one low
            s_q    = (s_rem >= {{F{1'b0}}, csdm_pkg::SIN_DIV[k]}) ? s_q0 + 1'b1 : s_q0;
            c_q    = (c_rem >= {{F{1'b0}}, csdm_pkg::COS_DIV[k]}) ? c_q0 + 1'b1 : c_q0;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_car_reg[k] <= car_in;
                p_s_reg[k]   <= s_p;
                p_c_reg[k]   <= c_p;
                m_car_reg[k] <= p_car_reg[k];
                m_sp_reg[k]  <= p_s_reg[k];
                m_cp_reg[k]  <= p_c_reg[k];
                m_sm_reg[k]  <= p_s_reg[k] * csdm_pkg::SIN_RCP[k];
                m_cm_reg[k]  <= p_c_reg[k] * csdm_pkg::COS_RCP[k];
                c_car_reg[k] <= m_car_reg[k];
                c_s_reg[k]   <= csdm_pkg::ONE_Q30 - {1'b0, s_q};
                c_c_reg[k]   <= csdm_pkg::ONE_Q30 - {1'b0, c_q};
            end
        end
    end

    // ---------------- final sin/cos, radius scale ----------------
    logic [2*F:0]    f_sprod, f_cprod;
    csdm_pkg::ctl_t  f1_ctl_reg, f2_ctl_reg, f3_ctl_reg;
    logic [F-1:0]    f1_s_reg, f1_c_reg;
    logic [F:0]      f2_s_reg, f2_c_reg;
    logic [RW+F:0]   f3_s_reg, f3_c_reg;

    assign f_sprod = c_car_reg[NS-1].a * c_s_reg[NS-1];
    assign f_cprod = c_car_reg[NS-1].a2 * c_c_reg[NS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_ctl_reg <= c_car_reg[NS-1].ctl;
            f1_s_reg   <= f_sprod[2*F-1:F];
            f1_c_reg   <= f_cprod[2*F-1:F];
            f2_ctl_reg <= f1_ctl_reg;
            f2_s_reg   <= {1'b0, f1_s_reg};
            f2_c_reg   <= csdm_pkg::ONE_Q30 - {2'b00, f1_c_reg[F-1:1]};
            f3_ctl_reg <= f2_ctl_reg;
            f3_s_reg   <= f2_ctl_reg.r * f2_s_reg;
            f3_c_reg   <= f2_ctl_reg.r * f2_c_reg;
        end
    end

    // ---------------- round, sign, quarter turn, saturate ----------------
    logic [RW+F+1:0]      rnd_s, rnd_c;
    logic [OW:0]          mag_s, mag_c;
    logic signed [OW+1:0] rc, rs, ox, oy;
    logic [2*OW-1:0]      out_next, out_reg;

    function automatic logic [OW-1:0] sat16(input logic signed [OW+1:0] v);
        logic [OW-1:0] res;
        if (v > $signed({3'b000, {(OW-1){1'b1}}}))
        begin
            res = {1'b0, {(OW-1){1'b1}}};
        end
        else if (v < $signed({3'b111, {(OW-1){1'b0}}}))
        begin
            res = {1'b1, {(OW-1){1'b0}}};
        end
        else
        begin
            res = v[OW-1:0];
        end
        return res;
    endfunction

    always_comb
    begin
        rnd_s = {1'b0, f3_s_reg} + {{(RW+F+2-(B+15)){1'b0}}, 1'b1, {(B+14){1'b0}}};
        rnd_c = {1'b0, f3_c_reg} + {{(RW+F+2-(B+15)){1'b0}}, 1'b1, {(B+14){1'b0}}};
        mag_s = rnd_s[B+15+OW:B+15];
        mag_c = rnd_c[B+15+OW:B+15];
        rc    = $signed({1'b0, mag_c});
        rs    = f3_ctl_reg.nneg ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
        unique case (f3_ctl_reg.region)
            csdm_pkg::REG_RIGHT:
            begin
                ox = rc;
                oy = rs;
            end
            csdm_pkg::REG_BOTTOM:
            begin
                ox = rs;
                oy = -rc;
            end
            csdm_pkg::REG_TOP:
            begin
                ox = -rs;
                oy = rc;
            end
            default:
            begin
                ox = -rc;
                oy = -rs;
            end
        endcase
        out_next = {sat16(oy), sat16(ox)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tdata = out_reg;

endmodule
